@@ hw/rtl/rrg_pkg.sv @@
// Package for the reference ramp generator: widths, request and register codes,
// configuration and divider handshake types. No dependencies.
package rrg_pkg;

  localparam int unsigned DivW    = 32;   // dividend and quotient width
  localparam int unsigned StepW   = 23;   // divisor and step count width
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned FracW   = 16;   // Q16.16 fraction bits
  localparam int unsigned MsPerS  = 1000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STOP  = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE           = 3'd0,
    CFG_MAX_POS_TORQUE = 3'd1,
    CFG_MIN_NEG_TORQUE = 3'd2,
    CFG_MAX_POS_SPEED  = 3'd3,
    CFG_MIN_NEG_SPEED  = 3'd4,
    CFG_MIN_POS_SPEED  = 3'd5,
    CFG_MAX_NEG_SPEED  = 3'd6,
    CFG_LOOP_FREQ_HZ   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               mode;
    logic        [14:0] max_pos_torque;
    logic signed [15:0] min_neg_torque;
    logic signed [15:0] max_pos_speed;
    logic signed [15:0] min_neg_speed;
    logic signed [15:0] min_pos_speed;
    logic signed [15:0] max_neg_speed;
    logic        [15:0] loop_freq_hz;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [StepW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/rrg_if.sv @@
// Channel interfaces of the reference ramp generator: request, response, config write.
// Depends on rrg_pkg for field widths.
interface rrg_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [15:0]  target;
  logic [15:0]         duration_ms;
  logic signed [15:0]  measured_speed;

  modport source (output valid, req_type, target, duration_ms, measured_speed, input ready);
  modport sink   (input valid, req_type, target, duration_ms, measured_speed, output ready);
endinterface

interface rrg_rsp_if;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic signed [31:0]  reference_q16;
  logic                ramp_done;

  modport source (output valid, accepted, reference_q16, ramp_done, input ready);
  modport sink   (input valid, accepted, reference_q16, ramp_done, output ready);
endinterface

interface rrg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrg_pkg::CfgIdxW-1:0]  index;
  logic [rrg_pkg::CfgW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/rrg_cfg_regs.sv @@
// Configuration register file of the reference ramp generator.
// Depends on rrg_pkg and rrg_cfg_if.
module rrg_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrg_cfg_if.sink       cfg_i,
  output rrg_pkg::cfg_t cfg_o
);
  import rrg_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= 1'b1;
      cfg_q.max_pos_torque <= 15'd32767;
      cfg_q.min_neg_torque <= -16'sd32767;
      cfg_q.max_pos_speed  <= 16'sd32767;
      cfg_q.min_neg_speed  <= 16'sh8000;
      cfg_q.min_pos_speed  <= '0;
      cfg_q.max_neg_speed  <= '0;
      cfg_q.loop_freq_hz   <= 16'd1000;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_MODE:           cfg_q.mode           <= cfg_i.data[0];
        CFG_MAX_POS_TORQUE: cfg_q.max_pos_torque <= cfg_i.data[14:0];
        CFG_MIN_NEG_TORQUE: cfg_q.min_neg_torque <= cfg_i.data;
        CFG_MAX_POS_SPEED:  cfg_q.max_pos_speed  <= cfg_i.data;
        CFG_MIN_NEG_SPEED:  cfg_q.min_neg_speed  <= cfg_i.data;
        CFG_MIN_POS_SPEED:  cfg_q.min_pos_speed  <= cfg_i.data;
        CFG_MAX_NEG_SPEED:  cfg_q.max_neg_speed  <= cfg_i.data;
        CFG_LOOP_FREQ_HZ:   cfg_q.loop_freq_hz   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/rrg_serial_div.sv @@
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Depends on rrg_pkg. Divisor must be nonzero.
module rrg_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrg_pkg::div_req_t req_i,
  output rrg_pkg::div_rsp_t rsp_o
);
  import rrg_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivW-1:0]  quo_q;
  logic [StepW-1:0] rem_q, dvs_q;
  logic [StepW:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[StepW]) begin
        rem_q <= trial[StepW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[StepW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/reference_ramp_generator_core.sv @@
// Top level of the reference ramp generator: request sequencer, ramp state, response register.
// Depends on rrg_pkg, rrg_if, rrg_cfg_regs and rrg_serial_div.
//
// Ticks, stops, rejected and immediate starts pass from S_EVAL straight to
// S_DONE. A start with nonzero duration also passes S_DIVN and S_DIVQ: one shared
// bit-serial divider first turns duration_ms*loop_freq_hz into a step count
// (division by 1000, plus one) and then divides the Q16.16 distance by that
// count. One request is in work at a time; a new request is taken while the
// previous response still waits in the output register.
module reference_ramp_generator_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  rrg_req_if.sink   req_i,
  rrg_rsp_if.source rsp_o,
  rrg_cfg_if.sink   cfg_i
);
  import rrg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIVN, S_DIVQ, S_DONE
  } state_e;

  state_e state_q;
  cfg_t   cfg;

  req_type_e          req_q;
  logic signed [15:0] target_q, meas_q;
  logic [15:0]        dur_q;
  logic               ok_q, neg_q;
  logic [StepW-1:0]   n_q;
  logic signed [31:0] step_new_q;

  logic signed [31:0] accum_q, step_q;
  logic signed [15:0] final_q;
  logic [StepW-1:0]   steps_q;

  logic               rsp_valid_q, rsp_acc_q, rsp_done_q;
  logic signed [31:0] rsp_ref_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rrg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rrg_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic               win_ok, commit;
  logic signed [15:0] cur;
  logic signed [16:0] delta;
  logic [15:0]        mag;
  logic [31:0]        prod;

  always_comb begin
    if (!cfg.mode) begin
      win_ok = !(target_q > $signed({1'b0, cfg.max_pos_torque}) ||
                 target_q < cfg.min_neg_torque);
    end else begin
      win_ok = !(target_q > cfg.max_pos_speed || target_q < cfg.min_neg_speed ||
                 (target_q < cfg.min_pos_speed && target_q > cfg.max_neg_speed));
    end
  end

  // torque mode truncates toward zero, speed mode floors
  assign cur   = accum_q[31:16] +
                 16'((!cfg.mode && accum_q[31] && (accum_q[15:0] != '0)) ? 1 : 0);
  assign delta = 17'(target_q) - 17'(cur);
  assign mag   = delta[16] ? 16'(-delta) : delta[15:0];
  assign prod  = {16'b0, dur_q} * {16'b0, cfg.loop_freq_hz};

  always_comb begin
    div_req = '0;
    if (state_q == S_EVAL) begin
      div_req.start    = (req_q == REQ_START) && win_ok && (dur_q != '0);
      div_req.dividend = prod;
      div_req.divisor  = StepW'(MsPerS);
    end else if (state_q == S_DIVN) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = {mag, {FracW{1'b0}}};
      div_req.divisor  = div_rsp.quotient[StepW-1:0] + 1'b1;
    end
  end

  assign commit = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  logic signed [31:0] accum_d, step_d, goal;
  logic signed [15:0] final_d;
  logic [StepW-1:0]   steps_d;
  logic               acc_d, snap;
  logic signed [32:0] sum;

  always_comb begin
    accum_d = accum_q;
    step_d  = step_q;
    final_d = final_q;
    steps_d = steps_q;
    acc_d   = 1'b1;
    snap    = 1'b0;
    goal    = {final_q, {FracW{1'b0}}};
    sum     = 33'(accum_q) + 33'(step_q);
    case (req_q)
      REQ_START: begin
        acc_d = ok_q;
        if (ok_q && (dur_q == '0)) begin
          accum_d = {target_q, {FracW{1'b0}}};
          steps_d = '0;
          step_d  = '0;
        end else if (ok_q) begin
          final_d = target_q;
          steps_d = n_q;
          step_d  = step_new_q;
        end
      end
      REQ_TICK: begin
        if (steps_q > StepW'(1)) begin
          if (step_q == '0) begin
            snap = 1'b1;
          end else if (!step_q[31]) begin
            snap = (accum_q >= goal) || (meas_q >= final_q);
          end else begin
            snap = (accum_q <= goal) || (meas_q <= final_q);
          end
          if (!snap) begin
            if (sum[32] != sum[31]) begin
              accum_d = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
              accum_d = sum[31:0];
            end
            steps_d = steps_q - 1'b1;
          end
        end else if (steps_q == StepW'(1)) begin
          snap = 1'b1;
        end
        if (snap) begin
          accum_d = goal;
          steps_d = '0;
        end
      end
      REQ_STOP: begin
        steps_d = '0;
        step_d  = '0;
      end
      default: ;
    endcase
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.accepted      = rsp_acc_q;
  assign rsp_o.reference_q16 = rsp_ref_q;
  assign rsp_o.ramp_done     = rsp_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      rsp_acc_q   <= 1'b0;
      rsp_ref_q   <= '0;
      rsp_done_q  <= 1'b0;
      accum_q     <= '0;
      step_q      <= '0;
      final_q     <= '0;
      steps_q     <= '0;
    end else begin
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= div_req.start ? S_DIVN : S_DONE;
        end
        S_DIVN: begin
          if (div_rsp.done) begin
            state_q <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_rsp.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            accum_q    <= accum_d;
            step_q     <= step_d;
            final_q    <= final_d;
            steps_q    <= steps_d;
            rsp_acc_q  <= acc_d;
            rsp_ref_q  <= accum_d;
            rsp_done_q <= (steps_d == '0);
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q    <= req_type_e'(req_i.req_type);
      target_q <= req_i.target;
      dur_q    <= req_i.duration_ms;
      meas_q   <= req_i.measured_speed;
    end
    if (state_q == S_EVAL) begin
      ok_q <= win_ok;
    end
    if (state_q == S_DIVN && div_rsp.done) begin
      n_q   <= div_req.divisor;
      neg_q <= delta[16];
    end
    if (state_q == S_DIVQ && div_rsp.done) begin
      if (!neg_q) begin
        step_new_q <= div_rsp.quotient[31] ? 32'sh7fff_ffff : div_rsp.quotient;
      end else if (div_rsp.quotient > 32'h8000_0000) begin
        step_new_q <= 32'sh8000_0000;
      end else begin
        step_new_q <= -div_rsp.quotient;
      end
    end
  end

  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == S_EVAL || state_q == S_DIVN))
    else $error("divider started outside a start request");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIVN || state_q == S_DIVQ))
    else $error("divider result with no division pending");

  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && req_q == REQ_STOP) |=> (rsp_valid_q && rsp_done_q && steps_q == '0))
    else $error("stop did not clear the ramp");

  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && req_q == REQ_START && !ok_q) |=> ($stable(accum_q) && $stable(steps_q)))
    else $error("rejected start changed the ramp state");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for reference_ramp_generator_core: directed table, then random
// ramp sequences with random idling in four of six phases, checked against an in-bench
// predictor or fixed values. Depends on rrg_pkg, the rrg_*_if interfaces and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrg_pkg::*;

  localparam logic [1:0] ReqUnknown = 2'd3;
  localparam int CycleLimit  = 1_000_000;
  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = 250;
  localparam int HoldAtBeat  = 400;
  localparam int HoldCycles  = 600;
  localparam int DrainCycles = 100;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] reference_q16;
    logic               ramp_done;
  } ramp_out_t;

  typedef struct packed {
    logic               is_cfg;
    cfg_idx_e           reg_idx;
    logic        [15:0] reg_data;
    logic        [1:0]  kind;
    logic signed [15:0] tgt;
    logic        [15:0] dur;
    logic signed [15:0] meas;
    logic               typed;
    ramp_out_t          want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rrg_req_if req_if ();
  rrg_rsp_if rsp_if ();
  rrg_cfg_if cfg_if ();

  reference_ramp_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  cfg_t               ramp_cfg;
  logic signed [31:0] ref_acc;
  logic signed [31:0] step_inc;
  logic signed [15:0] goal_tgt;
  logic        [22:0] steps_rem;

  ramp_out_t pending_refs[$];
  dir_row_t  directed_rows[$];
  int        errors = 0;
  int        beats_out = 0;
  int        cycle_cnt;
  bit        idle_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] saturate32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int draw_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [15:0] pick_reg(int lo, int hi);
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return lo[15:0];
    if (r == 1) return hi[15:0];
    return 16'(draw_between(lo, hi));
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [15:0] d);
    case (idx)
      CFG_MODE:           ramp_cfg.mode = d[0];
      CFG_MAX_POS_TORQUE: ramp_cfg.max_pos_torque = d[14:0];
      CFG_MIN_NEG_TORQUE: ramp_cfg.min_neg_torque = d;
      CFG_MAX_POS_SPEED:  ramp_cfg.max_pos_speed = d;
      CFG_MIN_NEG_SPEED:  ramp_cfg.min_neg_speed = d;
      CFG_MIN_POS_SPEED:  ramp_cfg.min_pos_speed = d;
      CFG_MAX_NEG_SPEED:  ramp_cfg.max_neg_speed = d;
      CFG_LOOP_FREQ_HZ:   ramp_cfg.loop_freq_hz = d;
      default: ;
    endcase
  endfunction

  function automatic ramp_out_t advance_ramp(logic [1:0] kind, logic signed [15:0] tgt,
                                             logic [15:0] dur, logic signed [15:0] meas);
    int        t, m, cur, goal;
    int        mpt, mnt, mps, mns, mnps, mxns;
    longint    steps, span;
    bit        ok, snap;
    ramp_out_t res;
    t    = tgt;
    m    = meas;
    ok   = 1'b1;
    snap = 1'b0;
    mpt  = ramp_cfg.max_pos_torque;
    mnt  = $signed(ramp_cfg.min_neg_torque);
    mps  = $signed(ramp_cfg.max_pos_speed);
    mns  = $signed(ramp_cfg.min_neg_speed);
    mnps = $signed(ramp_cfg.min_pos_speed);
    mxns = $signed(ramp_cfg.max_neg_speed);
    goal = int'(goal_tgt) * 65536;
    case (kind)
      REQ_START: begin
        // torque mode truncates the whole part toward zero, speed mode floors it
        if (ramp_cfg.mode == 1'b0) begin
          cur = ref_acc / 65536;
          ok  = !(t > mpt || t < mnt);
        end else begin
          cur = ref_acc >>> 16;
          ok  = !(t > mps || t < mns || (t < mnps && t > mxns));
        end
        if (ok) begin
          if (dur == 16'd0) begin
            ref_acc   = t * 65536;
            steps_rem = '0;
            step_inc  = '0;
          end else begin
            steps     = longint'(dur) * longint'(ramp_cfg.loop_freq_hz) / 1000 + 1;
            span      = (longint'(t) - longint'(cur)) * 65536;
            goal_tgt  = tgt;
            steps_rem = steps[22:0];
            step_inc  = saturate32(span / steps);
          end
        end
      end
      REQ_TICK: begin
        if (steps_rem > 23'd1) begin
          if (step_inc == 0) snap = 1'b1;
          else if (step_inc > 0) snap = (ref_acc >= goal) || (m >= int'(goal_tgt));
          else snap = (ref_acc <= goal) || (m <= int'(goal_tgt));
          if (!snap) begin
            ref_acc   = saturate32(longint'(ref_acc) + longint'(step_inc));
            steps_rem = steps_rem - 23'd1;
          end
        end else if (steps_rem == 23'd1) begin
          snap = 1'b1;
        end
        if (snap) begin
          ref_acc   = goal;
          steps_rem = '0;
        end
      end
      REQ_STOP: begin
        steps_rem = '0;
        step_inc  = '0;
      end
      default: ;
    endcase
    res.accepted      = ok;
    res.reference_q16 = ref_acc;
    res.ramp_done     = (steps_rem == '0);
    return res;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e idx, logic [15:0] d);
    dir_row_t r;
    r          = '0;
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = d;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [1:0] kind, logic signed [15:0] tgt,
                                       logic [15:0] dur, logic signed [15:0] meas);
    dir_row_t r;
    r      = '0;
    r.kind = kind;
    r.tgt  = tgt;
    r.dur  = dur;
    r.meas = meas;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(logic [1:0] kind, logic signed [15:0] tgt,
                                         logic [15:0] dur, logic signed [15:0] meas,
                                         logic acc, logic [31:0] refq, logic done);
    dir_row_t r;
    r                    = req_row(kind, tgt, dur, meas);
    r.typed              = 1'b1;
    r.want.accepted      = acc;
    r.want.reference_q16 = refq;
    r.want.ramp_done     = done;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s expected %h, actual %h", $time, field, want, got);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, d);
  endtask

  // drop valid and wait until every outstanding response has been taken
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_refs.size() != 0);
  endtask

  task automatic offer_req(logic [1:0] kind, logic signed [15:0] tgt, logic [15:0] dur,
                           logic signed [15:0] meas, logic typed, ramp_out_t typed_out);
    int        gap;
    ramp_out_t pred;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= kind;
    req_if.target         <= tgt;
    req_if.duration_ms    <= dur;
    req_if.measured_speed <= meas;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = advance_ramp(kind, tgt, dur, meas);
    pending_refs.push_back(typed ? typed_out : pred);
  endtask

  initial begin : rsp_side
    int        stall;
    ramp_out_t want;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (beats_out == HoldAtBeat) stall = HoldCycles;
      else stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      beats_out++;
      if (pending_refs.size() == 0) begin
        report("unexpected beat, reference", 'x, rsp_if.reference_q16);
      end else begin
        want = pending_refs.pop_front();
        if (rsp_if.accepted !== want.accepted)
          report("accepted", want.accepted, rsp_if.accepted);
        if (rsp_if.reference_q16 !== want.reference_q16)
          report("reference_q16", want.reference_q16, rsp_if.reference_q16);
        if (rsp_if.ramp_done !== want.ramp_done)
          report("ramp_done", want.ramp_done, rsp_if.ramp_done);
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    int       sent, ticks, lo, hi, g, tv, mv, r;
    bit       wild;

    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= REQ_START;
    req_if.target         <= '0;
    req_if.duration_ms    <= '0;
    req_if.measured_speed <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= CFG_MODE;
    cfg_if.data           <= '0;

    idle_on                 = 1'b1;
    ramp_cfg.mode           = 1'b1;
    ramp_cfg.max_pos_torque = 15'd32767;
    ramp_cfg.min_neg_torque = -16'sd32767;
    ramp_cfg.max_pos_speed  = 16'sd32767;
    ramp_cfg.min_neg_speed  = -16'sd32768;
    ramp_cfg.min_pos_speed  = '0;
    ramp_cfg.max_neg_speed  = '0;
    ramp_cfg.loop_freq_hz   = 16'd1000;
    ref_acc                 = '0;
    step_inc                = '0;
    goal_tgt                = '0;
    steps_rem               = '0;

    // state after reset, immediate starts at both ends of the range
    directed_rows.push_back(fixed_row(REQ_TICK, 0, 0, 0, 1, 32'h0, 1));
    directed_rows.push_back(fixed_row(REQ_STOP, 0, 0, 0, 1, 32'h0, 1));
    directed_rows.push_back(fixed_row(ReqUnknown, -1, 16'hFFFF, -1, 1, 32'h0, 1));
    directed_rows.push_back(fixed_row(REQ_START, 32767, 0, 0, 1, 32'h7FFF0000, 1));
    directed_rows.push_back(fixed_row(REQ_START, -32768, 0, 0, 1, 32'h80000000, 1));
    directed_rows.push_back(fixed_row(REQ_START, 0, 0, 0, 1, 32'h0, 1));
    // longest ramp at default rate, one step, then snap on measured speed
    directed_rows.push_back(req_row(REQ_START, 1000, 16'hFFFF, 0));
    directed_rows.push_back(req_row(REQ_TICK, 0, 0, -32768));
    directed_rows.push_back(fixed_row(REQ_TICK, 0, 0, 32767, 1, 32'h03E80000, 1));
    // falling ramp, then cancel
    directed_rows.push_back(req_row(REQ_START, -5, 3, 0));
    directed_rows.push_back(req_row(REQ_TICK, 0, 0, 100));
    directed_rows.push_back(req_row(REQ_STOP, 0, 0, 0));
    // dead band
    directed_rows.push_back(cfg_row(CFG_MIN_POS_SPEED, 16'd100));
    directed_rows.push_back(cfg_row(CFG_MAX_NEG_SPEED, -16'sd100));
    directed_rows.push_back(req_row(REQ_START, 50, 0, 0));
    directed_rows.push_back(req_row(REQ_START, -50, 7, 0));
    directed_rows.push_back(fixed_row(REQ_START, 100, 0, 0, 1, 32'h00640000, 1));
    directed_rows.push_back(fixed_row(REQ_START, -100, 0, 0, 1, 32'hFF9C0000, 1));
    directed_rows.push_back(fixed_row(REQ_START, -32768, 0, 0, 1, 32'h80000000, 1));
    // zero tick rate: one step, saturated increment, snap on next tick
    directed_rows.push_back(cfg_row(CFG_LOOP_FREQ_HZ, 16'd0));
    directed_rows.push_back(fixed_row(REQ_START, 32767, 500, 0, 1, 32'h80000000, 0));
    directed_rows.push_back(fixed_row(REQ_TICK, 0, 0, 0, 1, 32'h7FFF0000, 1));
    // torque mode, widest window, fastest rate
    directed_rows.push_back(cfg_row(CFG_MODE, 16'd0));
    directed_rows.push_back(cfg_row(CFG_MIN_NEG_TORQUE, 16'h8000));
    directed_rows.push_back(cfg_row(CFG_LOOP_FREQ_HZ, 16'hFFFF));
    directed_rows.push_back(req_row(REQ_START, -32768, 1, 0));
    directed_rows.push_back(req_row(REQ_START, 32767, 16'hFFFF, 0));
    directed_rows.push_back(req_row(REQ_TICK, 0, 0, -32768));
    directed_rows.push_back(fixed_row(REQ_TICK, 0, 0, 32767, 1, 32'h7FFF0000, 1));
    // torque window closed to zero
    directed_rows.push_back(cfg_row(CFG_MAX_POS_TORQUE, 16'd0));
    directed_rows.push_back(cfg_row(CFG_MIN_NEG_TORQUE, 16'd0));
    directed_rows.push_back(fixed_row(REQ_START, 1, 0, 0, 0, 32'h7FFF0000, 1));
    directed_rows.push_back(fixed_row(REQ_START, -1, 0, 0, 0, 32'h7FFF0000, 1));
    directed_rows.push_back(fixed_row(REQ_START, 0, 0, 0, 1, 32'h0, 1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        if (i > 0 && !directed_rows[i-1].is_cfg) drain();
        write_reg(row.reg_idx, row.reg_data);
        if (i + 1 == directed_rows.size() || !directed_rows[i+1].is_cfg)
          cfg_if.valid <= 1'b0;
      end else begin
        offer_req(row.kind, row.tgt, row.dur, row.meas, row.typed, row.want);
      end
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      idle_on = (phase % 3 != 2);
      wild    = (phase % 3 == 1);
      write_reg(CFG_MODE, {15'd0, phase[0]});
      write_reg(CFG_MAX_POS_TORQUE, pick_reg(wild ? 0 : 1000, 32767));
      write_reg(CFG_MIN_NEG_TORQUE, pick_reg(-32768, wild ? 0 : -1000));
      write_reg(CFG_MAX_POS_SPEED, wild ? pick_reg(-32768, 32767) : pick_reg(1000, 32767));
      write_reg(CFG_MIN_NEG_SPEED, wild ? pick_reg(-32768, 32767) : pick_reg(-32768, -1000));
      write_reg(CFG_MIN_POS_SPEED, wild ? pick_reg(-32768, 32767) : pick_reg(0, 500));
      write_reg(CFG_MAX_NEG_SPEED, wild ? pick_reg(-32768, 32767) : pick_reg(-500, 0));
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_LOOP_FREQ_HZ, 16'd0);
      else if (r == 1) write_reg(CFG_LOOP_FREQ_HZ, 16'hFFFF);
      else if (r == 2) write_reg(CFG_LOOP_FREQ_HZ, 16'd1);
      else write_reg(CFG_LOOP_FREQ_HZ, 16'($urandom_range(1, 3000)));
      cfg_if.valid <= 1'b0;

      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 3) == 0) begin
          offer_req(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'b0, '0);
          sent++;
        end else begin
          if (ramp_cfg.mode == 1'b0) begin
            lo = $signed(ramp_cfg.min_neg_torque);
            hi = ramp_cfg.max_pos_torque;
          end else begin
            lo = $signed(ramp_cfg.min_neg_speed);
            hi = $signed(ramp_cfg.max_pos_speed);
          end
          if (lo <= hi && $urandom_range(0, 9) != 0) tv = draw_between(lo, hi);
          else tv = $urandom;
          r = $urandom_range(0, 19);
          if (r == 0) offer_req(REQ_START, 16'(tv), 0, 16'($urandom), 1'b0, '0);
          else if (r == 1)
            offer_req(REQ_START, 16'(tv), 16'($urandom), 16'($urandom), 1'b0, '0);
          else offer_req(REQ_START, 16'(tv), 16'($urandom_range(1, 40)), 16'($urandom),
                         1'b0, '0);
          sent++;
          ticks = $urandom_range(1, 30);
          repeat (ticks) begin
            // mostly keep the measured speed behind the target so the ramp runs on
            g = goal_tgt;
            if ($urandom_range(0, 6) == 0) mv = $urandom;
            else if (step_inc > 0 && g > -32768) mv = draw_between(-32768, g - 1);
            else if (step_inc < 0 && g < 32767) mv = draw_between(g + 1, 32767);
            else mv = $urandom;
            offer_req(REQ_TICK, 16'($urandom), 16'($urandom), 16'(mv), 1'b0, '0);
            sent++;
          end
          if ($urandom_range(0, 3) == 0) begin
            offer_req(REQ_STOP, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_refs.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
